[hw/rtl/usv_pkg.sv]
// ----------------------------------------------------------------------------
// usv_pkg: shared types and constants for the UTF-8 stream validator
// Byte class limits, code point limits and the tracking state record.
// ----------------------------------------------------------------------------
package usv_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CpWidth   = 21;

   // Lead byte class limits.
   localparam logic [ByteWidth-1:0] Lead2Lo = 8'hC2;
   localparam logic [ByteWidth-1:0] Lead2Hi = 8'hDF;
   localparam logic [ByteWidth-1:0] Lead3Lo = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead3Hi = 8'hEF;
   localparam logic [ByteWidth-1:0] Lead4Lo = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead4Hi = 8'hF4;
   localparam logic [ByteWidth-1:0] AsciiHi = 8'h7F;
   localparam logic [ByteWidth-1:0] NulByte = 8'h00;

   // Continuation bytes have the form 10xxxxxx.
   localparam logic [1:0] ContTag = 2'b10;

   // Code point limits.
   localparam logic [CpWidth-1:0] Min3Byte   = 21'h000800;
   localparam logic [CpWidth-1:0] Min4Byte   = 21'h010000;
   localparam logic [CpWidth-1:0] SurrLo     = 21'h00D800;
   localparam logic [CpWidth-1:0] SurrHi     = 21'h00DFFF;
   localparam logic [CpWidth-1:0] MaxCodePt  = 21'h10FFFF;

   // Sequence lengths, counted as continuation bytes.
   localparam logic [1:0] SeqNone = 2'd0;
   localparam logic [1:0] SeqTwo  = 2'd1;
   localparam logic [1:0] SeqThree = 2'd2;
   localparam logic [1:0] SeqFour = 2'd3;

   typedef struct packed {
      logic [1:0]         pending;
      logic [1:0]         seq_len;
      logic [CpWidth-1:0] partial_cp;
      logic               error;
   } usv_state_type;

   localparam usv_state_type StateClear = '{
      pending:    2'd0,
      seq_len:    SeqNone,
      partial_cp: '0,
      error:      1'b0
   };

endpackage

[hw/rtl/usv_if.sv]
// ----------------------------------------------------------------------------
// usv_req_if / usv_rsp_if: valid/ready channels of the UTF-8 stream validator
// The request channel carries string bytes, the response channel verdicts.
// ----------------------------------------------------------------------------
interface usv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface usv_rsp_if;
   logic valid;
   logic ready;
   logic string_valid;

   modport source (output valid, output string_valid, input ready);
   modport sink   (input valid, input string_valid, output ready);
endinterface

[hw/rtl/usv_step.sv]
// ----------------------------------------------------------------------------
// usv_step: next-state logic of the UTF-8 stream validator
// Takes one byte against the tracking state and gives the updated state.
// ----------------------------------------------------------------------------
module usv_step (
   input  usv_pkg::usv_state_type cur_state,
   input  logic [7:0]             data_byte,
   output usv_pkg::usv_state_type nxt_state
);
   import usv_pkg::*;

   logic [CpWidth-1:0] cp_ext;
   logic [1:0]         pend_dec;
   logic               range_bad;

   assign cp_ext   = {cur_state.partial_cp[CpWidth-7:0], data_byte[5:0]};
   assign pend_dec = cur_state.pending - 2'd1;

   always_comb begin
      range_bad = ((cur_state.seq_len == SeqThree) && (cp_ext < Min3Byte)) ||
                  ((cur_state.seq_len == SeqFour) && (cp_ext < Min4Byte)) ||
                  ((cp_ext >= SurrLo) && (cp_ext <= SurrHi)) ||
                  (cp_ext > MaxCodePt);
   end

   always_comb begin
      nxt_state = cur_state;
      if (!cur_state.error) begin
         if (cur_state.pending == 2'd0) begin
            // Expecting the start of a new character.
            case (data_byte) inside
               NulByte: begin
                  nxt_state.error = 1'b1;
               end
               [8'h01:AsciiHi]: begin
               end
               [Lead2Lo:Lead2Hi]: begin
                  nxt_state.pending    = 2'd1;
                  nxt_state.seq_len    = SeqTwo;
                  nxt_state.partial_cp = {16'd0, data_byte[4:0]};
               end
               [Lead3Lo:Lead3Hi]: begin
                  nxt_state.pending    = 2'd2;
                  nxt_state.seq_len    = SeqThree;
                  nxt_state.partial_cp = {17'd0, data_byte[3:0]};
               end
               [Lead4Lo:Lead4Hi]: begin
                  nxt_state.pending    = 2'd3;
                  nxt_state.seq_len    = SeqFour;
                  nxt_state.partial_cp = {18'd0, data_byte[2:0]};
               end
               default: begin
                  nxt_state.error = 1'b1;
               end
            endcase
         end else if (data_byte[7:6] != ContTag) begin
            nxt_state.error = 1'b1;
         end else if (pend_dec != 2'd0) begin
            nxt_state.pending    = pend_dec;
            nxt_state.partial_cp = cp_ext;
         end else begin
            // Sequence complete: check overlong forms, surrogates and range.
            nxt_state.pending    = 2'd0;
            nxt_state.seq_len    = SeqNone;
            nxt_state.partial_cp = '0;
            nxt_state.error      = range_bad;
         end
      end
   end

endmodule

[hw/rtl/utf8_stream_validator_top.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator_top: well-formed UTF-8 check over a byte stream
// Takes one byte per word and gives one verdict word per string.
// ----------------------------------------------------------------------------
// The block takes one byte of a string per request word and, on the word
// marked as the last byte, returns one response word whose string_valid bit
// is 1 when the whole string was well-formed UTF-8. A byte is taken every
// clock cycle while no verdict stalls: the tracking state is updated in the
// same cycle the word is accepted, and the verdict sits in a one-deep output
// register, so it appears in the cycle after the last byte. The only stall
// comes from the response side: while a verdict waits in the output register
// and the sink does not take it, no new byte is accepted. Bytes that are not
// the last of a string produce no response word. After a verdict all
// tracking state returns to its reset value, so the next word starts a new
// string. No configuration is needed and no clearing pass follows reset.
// ----------------------------------------------------------------------------
module utf8_stream_validator_top (
   input logic    clock,
   input logic    reset,
   usv_req_if.sink   req_chan,
   usv_rsp_if.source rsp_chan
);
   import usv_pkg::*;

   // Tracking state: pending continuations, sequence length, the code point
   // built so far and the sticky error flag.
   usv_state_type state_ff;
   usv_state_type state_in;
   usv_state_type step_state;

   // Output register holding one verdict.
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic verdict_ff;
   logic verdict_in;

   logic req_take;

   usv_step u_step (
      .cur_state (state_ff),
      .data_byte (req_chan.data_byte),
      .nxt_state (step_state)
   );

   // A new byte is taken whenever the output register is empty or is being
   // emptied in this same cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      verdict_in   = verdict_ff;
      if (req_take) begin
         if (req_chan.last_byte) begin
            // The string ends here: a sequence still open counts as an error.
            state_in     = StateClear;
            rsp_valid_in = 1'b1;
            verdict_in   = !step_state.error && (step_state.pending == 2'd0);
         end else begin
            state_in = step_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateClear;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.string_valid = verdict_ff;

endmodule

[hw/rtl/usv_checker.sv]
// ----------------------------------------------------------------------------
// usv_checker: port-level checks of the UTF-8 stream validator
// Watches the request and response words and flags ordering slips.
// ----------------------------------------------------------------------------
module usv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_string_valid
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // A stalled verdict stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_string_valid))
      else $error("usv: stalled verdict changed or dropped");

   // Every accepted last byte yields a verdict in the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take && req_last_byte |=> rsp_valid)
      else $error("usv: last byte gave no verdict");

   // A verdict only appears after a last byte was accepted.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_take && req_last_byte))
      else $error("usv: verdict without a last byte");

   // A string ending in NUL is never valid.
   a_nul_rejected: assert property (@(posedge clock) disable iff (reset)
      req_take && req_last_byte && (req_data_byte == 8'h00) |=> !rsp_string_valid)
      else $error("usv: string ending in NUL accepted");

   // No byte is taken while a verdict waits and the sink holds off.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("usv: byte taken while verdict stalled");

endmodule

bind utf8_stream_validator_top usv_checker u_usv_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_data_byte    (req_chan.data_byte),
   .req_last_byte    (req_chan.last_byte),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_string_valid (rsp_chan.string_valid)
);
